>>> design/scpa_pkg.sv
// ----------------------------------------------------------------------------
// scpa_pkg
// Shared constants, size-class tables, sequencer codes and the command and
// status bundles between the controller and the datapath of the allocator.
// ----------------------------------------------------------------------------
package scpa_pkg;

   localparam int NUM_PAGES = 64;
   localparam int PAGE_AW   = 6;
   localparam int LINK_W    = 7;
   localparam int MAP_AW    = 8;
   localparam int WORD_W    = 64;

   localparam logic [LINK_W-1:0] LINK_NULL    = 7'd64;
   localparam logic [LINK_W-1:0] LAST_PAGE    = 7'd63;
   localparam logic [11:0]       HEADER_BYTES = 12'd48;
   localparam logic [18:0]       PAGE_BYTES   = 19'd4096;
   localparam logic [18:0]       POOL_BYTES   = 19'd262144;
   localparam logic [18:0]       SMALL_MAX    = 19'd2048;

   localparam logic [3:0] TAG_FREE  = 4'd15;
   localparam logic [3:0] TAG_LARGE = 4'd14;
   localparam logic [3:0] TAG_CONT  = 4'd13;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   localparam logic CMD_FREE = 1'b1;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_DISPATCH = 5'd1;
   localparam logic [4:0] S_CW_RD    = 5'd2;
   localparam logic [4:0] S_CW_CHK   = 5'd3;
   localparam logic [4:0] S_FRESH_RD = 5'd4;
   localparam logic [4:0] S_FRESH_WR = 5'd5;
   localparam logic [4:0] S_CLR      = 5'd6;
   localparam logic [4:0] S_SR_RD    = 5'd7;
   localparam logic [4:0] S_SR_CHK   = 5'd8;
   localparam logic [4:0] S_L_RD     = 5'd9;
   localparam logic [4:0] S_L_CHK    = 5'd10;
   localparam logic [4:0] S_L_HEAD   = 5'd11;
   localparam logic [4:0] S_L_CONT   = 5'd12;
   localparam logic [4:0] S_D_START  = 5'd13;
   localparam logic [4:0] S_D_RD     = 5'd14;
   localparam logic [4:0] S_D_CHK    = 5'd15;
   localparam logic [4:0] S_D_END    = 5'd16;
   localparam logic [4:0] S_D_FIX    = 5'd17;
   localparam logic [4:0] S_F_RD     = 5'd18;
   localparam logic [4:0] S_F_CHK    = 5'd19;
   localparam logic [4:0] S_FL_LOOP  = 5'd20;
   localparam logic [4:0] S_FS_RD    = 5'd21;
   localparam logic [4:0] S_FS_CHK   = 5'd22;
   localparam logic [4:0] S_U_START  = 5'd23;
   localparam logic [4:0] S_U_RD     = 5'd24;
   localparam logic [4:0] S_U_CHK    = 5'd25;
   localparam logic [4:0] S_PF       = 5'd26;
   localparam logic [4:0] S_FIN      = 5'd27;

   typedef struct packed {
      logic [4:0] state;
      logic       accept;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_free_cmd;
      logic req_zero;
      logic is_small;
      logic need_big;
      logic p_null;
      logic cnt_nz;
      logic fhead_null;
      logic w_last;
      logic word_full;
      logic run_hit;
      logic i_last;
      logic i_lt_need;
      logic f_bad;
      logic f_large;
      logic f_sbad;
      logic fl_more;
      logic bit_busy;
      logic last_slot;
      logic head_is_pg;
      logic link_is_pg;
      logic out_free;
   } dp_stat_type;

   function automatic logic [11:0] class_bytes(input logic [2:0] c);
      return 12'd16 << c;
   endfunction

   function automatic logic [8:0] slots_of(input logic [2:0] c);
      logic [8:0] s;
      unique case (c)
         3'd0: s = 9'd253;
         3'd1: s = 9'd126;
         3'd2: s = 9'd63;
         3'd3: s = 9'd31;
         3'd4: s = 9'd15;
         3'd5: s = 9'd7;
         3'd6: s = 9'd3;
         default: s = 9'd1;
      endcase
      return s;
   endfunction

   function automatic logic [12:0] class_span(input logic [2:0] c);
      logic [12:0] s;
      unique case (c)
         3'd0: s = 13'd4048;
         3'd1: s = 13'd4032;
         3'd2: s = 13'd4032;
         3'd3: s = 13'd3968;
         3'd4: s = 13'd3840;
         3'd5: s = 13'd3584;
         3'd6: s = 13'd3072;
         default: s = 13'd2048;
      endcase
      return s;
   endfunction

endpackage

>>> design/scpa_ctrl.sv
// ----------------------------------------------------------------------------
// scpa_ctrl
// Sequencer of the allocator: steps through list walks, page scans and
// bookkeeping writes, one micro-step per state, from datapath status.
// ----------------------------------------------------------------------------
module scpa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  scpa_pkg::dp_stat_type  dp_stat,
   output scpa_pkg::ctrl_cmd_type ctrl_cmd
);

   logic [4:0] state_ff;
   logic [4:0] state_in;

   assign req_tready      = (state_ff == scpa_pkg::S_IDLE);
   assign ctrl_cmd.state  = state_ff;
   assign ctrl_cmd.accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scpa_pkg::S_IDLE: begin
            if (req_tvalid) state_in = scpa_pkg::S_DISPATCH;
         end
         scpa_pkg::S_DISPATCH: begin
            if (dp_stat.is_free_cmd) state_in = scpa_pkg::S_F_RD;
            else if (dp_stat.req_zero) state_in = scpa_pkg::S_FIN;
            else if (dp_stat.is_small) state_in = scpa_pkg::S_CW_RD;
            else if (dp_stat.need_big) state_in = scpa_pkg::S_FIN;
            else state_in = scpa_pkg::S_L_RD;
         end
         scpa_pkg::S_CW_RD: begin
            state_in = dp_stat.p_null ? scpa_pkg::S_FRESH_RD : scpa_pkg::S_CW_CHK;
         end
         scpa_pkg::S_CW_CHK: begin
            state_in = dp_stat.cnt_nz ? scpa_pkg::S_SR_RD : scpa_pkg::S_CW_RD;
         end
         scpa_pkg::S_FRESH_RD: begin
            state_in = dp_stat.fhead_null ? scpa_pkg::S_FIN : scpa_pkg::S_FRESH_WR;
         end
         scpa_pkg::S_FRESH_WR: state_in = scpa_pkg::S_CLR;
         scpa_pkg::S_CLR: begin
            if (dp_stat.w_last) state_in = scpa_pkg::S_SR_RD;
         end
         scpa_pkg::S_SR_RD: state_in = scpa_pkg::S_SR_CHK;
         scpa_pkg::S_SR_CHK: begin
            if (!dp_stat.word_full || dp_stat.w_last) state_in = scpa_pkg::S_FIN;
            else state_in = scpa_pkg::S_SR_RD;
         end
         scpa_pkg::S_L_RD: state_in = scpa_pkg::S_L_CHK;
         scpa_pkg::S_L_CHK: begin
            if (dp_stat.run_hit) state_in = scpa_pkg::S_L_HEAD;
            else if (dp_stat.i_last) state_in = scpa_pkg::S_FIN;
            else state_in = scpa_pkg::S_L_RD;
         end
         scpa_pkg::S_L_HEAD: state_in = scpa_pkg::S_L_CONT;
         scpa_pkg::S_L_CONT: begin
            if (!dp_stat.i_lt_need) state_in = scpa_pkg::S_D_START;
         end
         scpa_pkg::S_D_START: state_in = scpa_pkg::S_D_RD;
         scpa_pkg::S_D_RD: begin
            state_in = dp_stat.p_null ? scpa_pkg::S_D_END : scpa_pkg::S_D_CHK;
         end
         scpa_pkg::S_D_CHK: state_in = scpa_pkg::S_D_RD;
         scpa_pkg::S_D_END: state_in = scpa_pkg::S_D_FIX;
         scpa_pkg::S_D_FIX: state_in = scpa_pkg::S_FIN;
         scpa_pkg::S_F_RD: state_in = scpa_pkg::S_F_CHK;
         scpa_pkg::S_F_CHK: begin
            if (dp_stat.f_bad) state_in = scpa_pkg::S_FIN;
            else if (dp_stat.f_large) state_in = scpa_pkg::S_FL_LOOP;
            else if (dp_stat.f_sbad) state_in = scpa_pkg::S_FIN;
            else state_in = scpa_pkg::S_FS_RD;
         end
         scpa_pkg::S_FL_LOOP: begin
            if (!dp_stat.fl_more) state_in = scpa_pkg::S_FIN;
         end
         scpa_pkg::S_FS_RD: state_in = scpa_pkg::S_FS_CHK;
         scpa_pkg::S_FS_CHK: begin
            if (dp_stat.bit_busy && dp_stat.last_slot) state_in = scpa_pkg::S_U_START;
            else state_in = scpa_pkg::S_FIN;
         end
         scpa_pkg::S_U_START: begin
            state_in = dp_stat.head_is_pg ? scpa_pkg::S_PF : scpa_pkg::S_U_RD;
         end
         scpa_pkg::S_U_RD: begin
            state_in = dp_stat.p_null ? scpa_pkg::S_PF : scpa_pkg::S_U_CHK;
         end
         scpa_pkg::S_U_CHK: begin
            state_in = dp_stat.link_is_pg ? scpa_pkg::S_PF : scpa_pkg::S_U_RD;
         end
         scpa_pkg::S_PF: state_in = scpa_pkg::S_FIN;
         scpa_pkg::S_FIN: begin
            if (dp_stat.out_free) state_in = scpa_pkg::S_IDLE;
         end
         default: state_in = scpa_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scpa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/scpa_dpath.sv
// ----------------------------------------------------------------------------
// scpa_dpath
// Page tables, slot bitmaps, list heads, byte total and the result register;
// performs the micro-step named by the controller and reports its flags.
// ----------------------------------------------------------------------------
module scpa_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  scpa_pkg::ctrl_cmd_type ctrl_cmd,
   output scpa_pkg::dp_stat_type  dp_stat,
   input  logic                   req_tuser,
   input  logic [39:0]            req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [39:0]            rsp_tdata
);

   // page tables with valid bits, slot bitmap words
   logic [3:0]  tag_mem  [scpa_pkg::NUM_PAGES];
   logic [8:0]  cnt_mem  [scpa_pkg::NUM_PAGES];
   logic [6:0]  link_mem [scpa_pkg::NUM_PAGES];
   logic [63:0] map_mem  [4*scpa_pkg::NUM_PAGES];
   logic [63:0] tag_vld_ff, cnt_vld_ff, link_vld_ff;

   logic [3:0]  tag_q_ff;
   logic [8:0]  cnt_q_ff;
   logic [6:0]  link_q_ff;
   logic [63:0] map_q_ff;
   logic        tag_qv_ff, cnt_qv_ff, link_qv_ff;
   logic [5:0]  pa_ff;

   logic [5:0]  pa, wa;
   logic [7:0]  ma, map_wa;
   logic        tag_we, cnt_we, link_we, map_we;
   logic [3:0]  tag_wd;
   logic [8:0]  cnt_wd;
   logic [6:0]  link_wd;
   logic [63:0] map_wd;

   logic        cmd_ff, cmd_in;
   logic [18:0] req_ff, req_in;
   logic [17:0] off_ff, off_in;
   logic [2:0]  cls_ff, cls_in;
   logic        small_ff, small_in, big_ff, big_in;
   logic [6:0]  need_ff, need_in;
   logic [6:0]  p_ff, p_in, i_ff, i_in, run_ff, run_in, tail_ff, tail_in;
   logic [6:0]  link_pg_ff, link_pg_in;
   logic [5:0]  start_ff, start_in;
   logic [1:0]  w_ff, w_in;
   logic [8:0]  cur_cnt_ff, cur_cnt_in;
   logic [7:0]  s_ff, s_in;
   logic [1:0]  status_ff, status_in;
   logic [17:0] granted_ff, granted_in;
   logic [18:0] total_ff, total_in;
   logic [6:0]  fhead_ff, fhead_in;
   logic [6:0]  chead_ff [8];
   logic [6:0]  chead_in [8];
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [17:0] rsp_granted_ff, rsp_granted_in;
   logic [18:0] rsp_free_ff, rsp_free_in;

   logic [18:0] req_bytes;
   logic [2:0]  cls_calc;
   logic [19:0] need_sum;
   logic [5:0]  pg;
   logic [11:0] o, o_sub, s_full;
   logic [11:0] cb;
   logic [8:0]  slots;
   logic [12:0] span;
   logic [3:0]  tag_rd;
   logic [8:0]  cnt_rd;
   logic [6:0]  link_rd;
   logic [5:0]  zidx;
   logic [7:0]  fl_sum;
   logic        in_run;

   assign req_bytes = req_tdata[18:0];
   assign need_sum  = 20'(req_bytes) + 20'd4143;
   assign pg        = off_ff[17:12];
   assign o         = off_ff[11:0];
   assign o_sub     = o - scpa_pkg::HEADER_BYTES;
   assign s_full    = o_sub >> ({1'b0, tag_rd[2:0]} + 4'd4);
   assign cb        = scpa_pkg::class_bytes(cls_ff);
   assign slots     = scpa_pkg::slots_of(cls_ff);
   assign span      = scpa_pkg::class_span(cls_ff);
   assign tag_rd    = tag_qv_ff ? tag_q_ff : scpa_pkg::TAG_FREE;
   assign cnt_rd    = cnt_qv_ff ? cnt_q_ff : 9'd0;
   assign link_rd   = link_qv_ff ? link_q_ff :
                      ((pa_ff == 6'd0) ? scpa_pkg::LINK_NULL : {1'b0, pa_ff - 6'd1});
   assign fl_sum    = 8'(pg) + 8'(i_ff);
   assign in_run    = (p_ff >= {1'b0, start_ff}) &&
                      (8'(p_ff) < (8'(start_ff) + 8'(need_ff)));

   always_comb begin
      cls_calc = 3'd7;
      for (int k = 7; k >= 0; k--) begin
         if (req_bytes <= (19'd16 << k)) cls_calc = 3'(k);
      end
   end

   always_comb begin
      zidx = 6'd0;
      for (int k = 63; k >= 0; k--) begin
         if (!map_q_ff[k]) zidx = 6'(k);
      end
   end

   // status towards the controller
   always_comb begin
      dp_stat.is_free_cmd = (cmd_ff == scpa_pkg::CMD_FREE);
      dp_stat.req_zero    = (req_ff == 19'd0);
      dp_stat.is_small    = small_ff;
      dp_stat.need_big    = big_ff;
      dp_stat.p_null      = (p_ff == scpa_pkg::LINK_NULL);
      dp_stat.cnt_nz      = (cnt_rd != 9'd0);
      dp_stat.fhead_null  = (fhead_ff == scpa_pkg::LINK_NULL);
      dp_stat.w_last      = (w_ff == 2'd3);
      dp_stat.word_full   = &map_q_ff;
      dp_stat.run_hit     = (tag_rd == scpa_pkg::TAG_FREE) && ((run_ff + 7'd1) == need_ff);
      dp_stat.i_last      = (i_ff == scpa_pkg::LAST_PAGE);
      dp_stat.i_lt_need   = (i_ff < need_ff);
      dp_stat.f_bad       = (tag_rd == scpa_pkg::TAG_FREE) || (tag_rd == scpa_pkg::TAG_CONT) ||
                            (o < scpa_pkg::HEADER_BYTES) ||
                            ((tag_rd != scpa_pkg::TAG_LARGE) && tag_rd[3]);
      dp_stat.f_large     = (tag_rd == scpa_pkg::TAG_LARGE);
      dp_stat.f_sbad      = (s_full >= 12'(scpa_pkg::slots_of(tag_rd[2:0])));
      dp_stat.fl_more     = (i_ff < need_ff) && (fl_sum < 8'(scpa_pkg::NUM_PAGES));
      dp_stat.bit_busy    = map_q_ff[s_ff[5:0]];
      dp_stat.last_slot   = ((cur_cnt_ff + 9'd1) == slots);
      dp_stat.head_is_pg  = (chead_ff[cls_ff] == {1'b0, pg});
      dp_stat.link_is_pg  = (link_rd == {1'b0, pg});
      dp_stat.out_free    = !rsp_valid_ff || rsp_tready;
   end

   // read addresses
   always_comb begin
      pa = 6'd0;
      ma = {p_ff[5:0], w_ff};
      unique case (ctrl_cmd.state)
         scpa_pkg::S_CW_RD, scpa_pkg::S_D_RD, scpa_pkg::S_U_RD: pa = p_ff[5:0];
         scpa_pkg::S_FRESH_RD: pa = fhead_ff[5:0];
         scpa_pkg::S_L_RD:     pa = i_ff[5:0];
         scpa_pkg::S_F_RD:     pa = pg;
         scpa_pkg::S_FS_RD:    ma = {pg, s_ff[7:6]};
         default: pa = 6'd0;
      endcase
   end

   always_comb begin
      cmd_in = cmd_ff; req_in = req_ff; off_in = off_ff; cls_in = cls_ff;
      small_in = small_ff; big_in = big_ff; need_in = need_ff;
      p_in = p_ff; i_in = i_ff; run_in = run_ff; tail_in = tail_ff;
      link_pg_in = link_pg_ff; start_in = start_ff; w_in = w_ff;
      cur_cnt_in = cur_cnt_ff; s_in = s_ff; status_in = status_ff;
      granted_in = granted_ff; total_in = total_ff; fhead_in = fhead_ff;
      chead_in = chead_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff; rsp_granted_in = rsp_granted_ff;
      rsp_free_in = rsp_free_ff;
      tag_we = 1'b0; cnt_we = 1'b0; link_we = 1'b0; map_we = 1'b0;
      wa = p_ff[5:0]; tag_wd = scpa_pkg::TAG_FREE; cnt_wd = 9'd0;
      link_wd = scpa_pkg::LINK_NULL; map_wd = '0; map_wa = {p_ff[5:0], w_ff};
      unique case (ctrl_cmd.state)
         scpa_pkg::S_IDLE: begin
            if (ctrl_cmd.accept) begin
               cmd_in     = req_tuser;
               req_in     = req_bytes;
               off_in     = req_tdata[36:19];
               cls_in     = cls_calc;
               small_in   = (req_bytes <= scpa_pkg::SMALL_MAX);
               need_in    = need_sum[18:12];
               big_in     = (need_sum[19:12] > 8'(scpa_pkg::NUM_PAGES));
               status_in  = scpa_pkg::STATUS_OK;
               granted_in = '0;
            end
         end
         scpa_pkg::S_DISPATCH: begin
            if (cmd_ff == scpa_pkg::CMD_FREE) begin
               status_in = scpa_pkg::STATUS_OK;
            end else if (req_ff == 19'd0) begin
               status_in = scpa_pkg::STATUS_INVALID;
            end else if (small_ff) begin
               p_in = chead_ff[cls_ff];
            end else if (big_ff) begin
               status_in = scpa_pkg::STATUS_NOSPACE;
            end else begin
               i_in   = 7'd0;
               run_in = 7'd0;
            end
         end
         scpa_pkg::S_CW_CHK: begin
            if (cnt_rd != 9'd0) begin
               cur_cnt_in = cnt_rd;
               w_in       = 2'd0;
            end else begin
               p_in = link_rd;
            end
         end
         scpa_pkg::S_FRESH_RD: begin
            if (fhead_ff == scpa_pkg::LINK_NULL) status_in = scpa_pkg::STATUS_NOSPACE;
            else p_in = fhead_ff;
         end
         scpa_pkg::S_FRESH_WR: begin
            fhead_in         = link_rd;
            tag_we           = 1'b1;
            cnt_we           = 1'b1;
            link_we          = 1'b1;
            tag_wd           = {1'b0, cls_ff};
            cnt_wd           = slots;
            link_wd          = chead_ff[cls_ff];
            chead_in[cls_ff] = p_ff;
            total_in         = total_ff + 19'(span) - scpa_pkg::PAGE_BYTES;
            cur_cnt_in       = slots;
            w_in             = 2'd0;
         end
         scpa_pkg::S_CLR: begin
            map_we = 1'b1;
            map_wd = '0;
            w_in   = w_ff + 2'd1;
         end
         scpa_pkg::S_SR_CHK: begin
            if (!(&map_q_ff)) begin
               map_we     = 1'b1;
               map_wd     = map_q_ff | (64'd1 << zidx);
               cnt_we     = 1'b1;
               cnt_wd     = cur_cnt_ff - 9'd1;
               total_in   = total_ff - 19'(cb);
               granted_in = {p_ff[5:0],
                             12'(scpa_pkg::HEADER_BYTES +
                                 (12'({w_ff, zidx}) << ({1'b0, cls_ff} + 4'd4)))};
               status_in  = scpa_pkg::STATUS_OK;
            end else if (w_ff == 2'd3) begin
               status_in = scpa_pkg::STATUS_NOSPACE;
            end else begin
               w_in = w_ff + 2'd1;
            end
         end
         scpa_pkg::S_L_CHK: begin
            if (tag_rd == scpa_pkg::TAG_FREE) begin
               if (run_ff == 7'd0) start_in = i_ff[5:0];
               run_in = run_ff + 7'd1;
            end else begin
               run_in = 7'd0;
            end
            if (!dp_stat.run_hit) begin
               i_in = i_ff + 7'd1;
               if (i_ff == scpa_pkg::LAST_PAGE) status_in = scpa_pkg::STATUS_NOSPACE;
            end
         end
         scpa_pkg::S_L_HEAD: begin
            wa     = start_ff;
            tag_we = 1'b1;
            tag_wd = scpa_pkg::TAG_LARGE;
            cnt_we = 1'b1;
            cnt_wd = 9'(need_ff);
            i_in   = 7'd1;
         end
         scpa_pkg::S_L_CONT: begin
            if (i_ff < need_ff) begin
               wa     = start_ff + i_ff[5:0];
               tag_we = 1'b1;
               tag_wd = scpa_pkg::TAG_CONT;
               i_in   = i_ff + 7'd1;
            end
         end
         scpa_pkg::S_D_START: begin
            p_in     = fhead_ff;
            tail_in  = scpa_pkg::LINK_NULL;
            fhead_in = scpa_pkg::LINK_NULL;
         end
         scpa_pkg::S_D_CHK: begin
            if (!in_run) begin
               if (tail_ff == scpa_pkg::LINK_NULL) begin
                  fhead_in = p_ff;
               end else begin
                  wa      = tail_ff[5:0];
                  link_we = 1'b1;
                  link_wd = p_ff;
               end
               tail_in = p_ff;
            end
            p_in = link_rd;
         end
         scpa_pkg::S_D_END: begin
            if (tail_ff != scpa_pkg::LINK_NULL) begin
               wa      = tail_ff[5:0];
               link_we = 1'b1;
               link_wd = scpa_pkg::LINK_NULL;
            end
         end
         scpa_pkg::S_D_FIX: begin
            wa         = start_ff;
            link_we    = 1'b1;
            link_wd    = scpa_pkg::LINK_NULL;
            total_in   = total_ff - {need_ff, 12'd0};
            granted_in = {start_ff, scpa_pkg::HEADER_BYTES};
            status_in  = scpa_pkg::STATUS_OK;
         end
         scpa_pkg::S_F_CHK: begin
            if (dp_stat.f_bad) begin
               status_in = scpa_pkg::STATUS_INVALID;
            end else if (tag_rd == scpa_pkg::TAG_LARGE) begin
               need_in = cnt_rd[6:0];
               i_in    = 7'd0;
            end else if (dp_stat.f_sbad) begin
               status_in = scpa_pkg::STATUS_INVALID;
            end else begin
               cls_in     = tag_rd[2:0];
               s_in       = s_full[7:0];
               cur_cnt_in = cnt_rd;
               link_pg_in = link_rd;
            end
         end
         scpa_pkg::S_FL_LOOP: begin
            if (dp_stat.fl_more) begin
               wa       = fl_sum[5:0];
               tag_we   = 1'b1;
               cnt_we   = 1'b1;
               link_we  = 1'b1;
               link_wd  = fhead_ff;
               fhead_in = {1'b0, fl_sum[5:0]};
               total_in = total_ff + scpa_pkg::PAGE_BYTES;
               i_in     = i_ff + 7'd1;
            end
         end
         scpa_pkg::S_FS_CHK: begin
            if (!map_q_ff[s_ff[5:0]]) begin
               status_in = scpa_pkg::STATUS_INVALID;
            end else begin
               map_we   = 1'b1;
               map_wa   = {pg, s_ff[7:6]};
               map_wd   = map_q_ff & ~(64'd1 << s_ff[5:0]);
               total_in = total_ff + 19'(cb);
               if (!dp_stat.last_slot) begin
                  wa     = pg;
                  cnt_we = 1'b1;
                  cnt_wd = cur_cnt_ff + 9'd1;
               end
            end
         end
         scpa_pkg::S_U_START: begin
            if (dp_stat.head_is_pg) chead_in[cls_ff] = link_pg_ff;
            else p_in = chead_ff[cls_ff];
         end
         scpa_pkg::S_U_CHK: begin
            if (link_rd == {1'b0, pg}) begin
               wa      = p_ff[5:0];
               link_we = 1'b1;
               link_wd = link_pg_ff;
            end else begin
               p_in = link_rd;
            end
         end
         scpa_pkg::S_PF: begin
            wa       = pg;
            tag_we   = 1'b1;
            cnt_we   = 1'b1;
            link_we  = 1'b1;
            link_wd  = fhead_ff;
            fhead_in = {1'b0, pg};
            total_in = total_ff + scpa_pkg::PAGE_BYTES - 19'(span);
         end
         scpa_pkg::S_FIN: begin
            if (dp_stat.out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_granted_in = granted_ff;
               rsp_free_in    = total_ff;
            end
         end
         default: begin
            status_in = status_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (tag_we) tag_mem[wa] <= tag_wd;
      if (cnt_we) cnt_mem[wa] <= cnt_wd;
      if (link_we) link_mem[wa] <= link_wd;
      if (map_we) map_mem[map_wa] <= map_wd;
      tag_q_ff   <= tag_mem[pa];
      cnt_q_ff   <= cnt_mem[pa];
      link_q_ff  <= link_mem[pa];
      map_q_ff   <= map_mem[ma];
      tag_qv_ff  <= tag_vld_ff[pa];
      cnt_qv_ff  <= cnt_vld_ff[pa];
      link_qv_ff <= link_vld_ff[pa];
      pa_ff      <= pa;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_vld_ff   <= '0;
         cnt_vld_ff   <= '0;
         link_vld_ff  <= '0;
         fhead_ff     <= scpa_pkg::LAST_PAGE;
         total_ff     <= scpa_pkg::POOL_BYTES;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 8; k++) chead_ff[k] <= scpa_pkg::LINK_NULL;
      end else begin
         if (tag_we) tag_vld_ff[wa] <= 1'b1;
         if (cnt_we) cnt_vld_ff[wa] <= 1'b1;
         if (link_we) link_vld_ff[wa] <= 1'b1;
         fhead_ff     <= fhead_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         chead_ff     <= chead_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      req_ff         <= req_in;
      off_ff         <= off_in;
      cls_ff         <= cls_in;
      small_ff       <= small_in;
      big_ff         <= big_in;
      need_ff        <= need_in;
      p_ff           <= p_in;
      i_ff           <= i_in;
      run_ff         <= run_in;
      tail_ff        <= tail_in;
      link_pg_ff     <= link_pg_in;
      start_ff       <= start_in;
      w_ff           <= w_in;
      cur_cnt_ff     <= cur_cnt_in;
      s_ff           <= s_in;
      status_ff      <= status_in;
      granted_ff     <= granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_free_ff    <= rsp_free_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_free_ff, rsp_granted_ff, rsp_status_ff};

endmodule

>>> design/size_class_page_allocator_core.sv
// ----------------------------------------------------------------------------
// size_class_page_allocator_core
// Page pool allocator with power-of-two size classes and multi-page runs.
// ----------------------------------------------------------------------------
// req channel: one beat per command, tuser 0 allocates, 1 frees
// rsp channel: one beat per command with status, granted offset, free bytes
// one command in flight; req_tready is high only while the sequencer idles
// latency per command depends on list and pool walks:
//   small alloc from a listed page: grows with each class list page walked
//   small alloc from a fresh page: the class list walk plus the bitmap clear
//   large alloc: grows with pages scanned, run length and free list pages
//   free: grows with run length, or with the class list walk when a page
//   returns to the pool
// the next command is taken while a result waits in the output register
// a stalled rsp holds the finished result; the sequencer waits at its end
// reset empties the class lists and puts every page on the free list;
// table valid bits clear at once, no clearing pass
module size_class_page_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,  // command
   input  logic [39:0] req_tdata,  // request_bytes, block_offset
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // status, granted_offset, free_bytes
);

   scpa_pkg::ctrl_cmd_type ctrl_cmd;
   scpa_pkg::dp_stat_type  dp_stat;

   scpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_stat    (dp_stat),
      .ctrl_cmd   (ctrl_cmd)
   );

   scpa_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctrl_cmd   (ctrl_cmd),
      .dp_stat    (dp_stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second beat taken while busy");

   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != scpa_pkg::STATUS_OK) |-> rsp_tdata[19:2] == 18'd0)
      else $error("offset given on failed command");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == scpa_pkg::STATUS_OK) ||
                     (rsp_tdata[1:0] == scpa_pkg::STATUS_NOSPACE) ||
                     (rsp_tdata[1:0] == scpa_pkg::STATUS_INVALID))
      else $error("undefined status");

endmodule

>>> verif/size_class_page_allocator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_page_allocator_core_tb
// Drives allocate and free beats into the page pool allocator and checks
// each response against a pool tracker kept inside the bench: size classes,
// multi-page runs, rejected frees, pool exhaustion and random traffic.
// ----------------------------------------------------------------------------
module size_class_page_allocator_core_tb;

   localparam logic CMD_ALLOC = ~scpa_pkg::CMD_FREE;
   localparam int   NPG       = 64;
   localparam int   PG_BYTES  = 4096;
   localparam int   HDR       = 48;
   localparam int   NCLS      = 8;
   localparam int   WATCHDOG  = 20000;

   typedef struct {
      logic [1:0]  status;
      logic [17:0] granted;
      logic [18:0] free_bytes;
   } grant_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser = 1'b0;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   size_class_page_allocator_core DUT (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // pool tracker
   logic [3:0]   pg_tag [NPG];
   int           pg_cnt [NPG];
   logic [255:0] pg_map [NPG];
   int           pg_link [NPG];
   int           free_head;
   int           cls_head [NCLS];
   int           pool_free;

   grant_type    grant_q [$];
   int           live_off [$];
   int           live_span [$];
   int           errors = 0;
   int           n_sent = 0;
   int           n_rsp = 0;
   int           idle_cnt = 0;
   bit           calm = 1'b0;
   logic [17:0]  last_grant;

   function automatic int cls_size(int c);
      return 16 << c;
   endfunction

   function automatic int cls_slots(int c);
      return (PG_BYTES - HDR) / cls_size(c);
   endfunction

   function automatic void pool_reset();
      for (int i = 0; i < NPG; i++) begin
         pg_tag[i] = scpa_pkg::TAG_FREE;
         pg_cnt[i] = 0;
         pg_map[i] = '0;
         pg_link[i] = (i == 0) ? NPG : i - 1;
      end
      free_head = NPG - 1;
      for (int c = 0; c < NCLS; c++) cls_head[c] = NPG;
      pool_free = NPG * PG_BYTES;
   endfunction

   function automatic void page_release(int p);
      pg_tag[p] = scpa_pkg::TAG_FREE;
      pg_cnt[p] = 0;
      pg_map[p] = '0;
      pg_link[p] = free_head;
      free_head = p;
   endfunction

   function automatic void alloc_slot(int c, output logic [1:0] st, output int gr);
      int sl;
      int p;
      int steps;
      int s;
      sl = cls_slots(c);
      p = cls_head[c];
      steps = 0;
      st = scpa_pkg::STATUS_NOSPACE;
      gr = 0;
      while (p < NPG && steps <= NPG) begin
         if (pg_cnt[p] != 0) break;
         steps++;
         p = pg_link[p];
      end
      if (p >= NPG || pg_cnt[p] == 0) begin
         if (free_head >= NPG) return;
         p = free_head;
         free_head = pg_link[p];
         pg_map[p] = '0;
         pg_tag[p] = 4'(c);
         pg_cnt[p] = sl;
         pg_link[p] = cls_head[c];
         cls_head[c] = p;
         pool_free = pool_free + sl * cls_size(c) - PG_BYTES;
      end
      for (s = 0; s < sl; s++) if (!pg_map[p][s]) break;
      if (s >= sl) return;
      pg_map[p][s] = 1'b1;
      pg_cnt[p]--;
      pool_free -= cls_size(c);
      gr = p * PG_BYTES + HDR + s * cls_size(c);
      st = scpa_pkg::STATUS_OK;
   endfunction

   function automatic void alloc_run(int req, output logic [1:0] st, output int gr);
      int need;
      int run;
      int start;
      int cur;
      int tail;
      int nxt;
      int steps;
      need = (req + HDR + PG_BYTES - 1) / PG_BYTES;
      st = scpa_pkg::STATUS_NOSPACE;
      gr = 0;
      run = 0;
      start = 0;
      if (need > NPG) return;
      for (int i = 0; i < NPG; i++) begin
         if (pg_tag[i] == scpa_pkg::TAG_FREE) begin
            if (run == 0) start = i;
            run++;
            if (run == need) break;
         end else begin
            run = 0;
         end
      end
      if (run != need) return;
      pg_tag[start] = scpa_pkg::TAG_LARGE;
      pg_cnt[start] = need;
      for (int i = 1; i < need; i++) pg_tag[start + i] = scpa_pkg::TAG_CONT;
      cur = free_head;
      tail = NPG;
      steps = 0;
      free_head = NPG;
      while (cur < NPG && steps <= NPG) begin
         steps++;
         nxt = pg_link[cur];
         if (!(cur >= start && cur < start + need)) begin
            if (tail == NPG) free_head = cur;
            else pg_link[tail] = cur;
            tail = cur;
         end
         cur = nxt;
      end
      if (tail != NPG) pg_link[tail] = NPG;
      pg_link[start] = NPG;
      pool_free -= need * PG_BYTES;
      gr = start * PG_BYTES + HDR;
      st = scpa_pkg::STATUS_OK;
   endfunction

   function automatic logic [1:0] release_block(int off);
      int pg;
      int o;
      int c;
      int sl;
      int s;
      int i;
      int n;
      int cur;
      int steps;
      pg = off / PG_BYTES;
      o = off % PG_BYTES;
      if (pg >= NPG) return scpa_pkg::STATUS_INVALID;
      if (pg_tag[pg] == scpa_pkg::TAG_FREE || pg_tag[pg] == scpa_pkg::TAG_CONT || o < HDR)
         return scpa_pkg::STATUS_INVALID;
      if (pg_tag[pg] == scpa_pkg::TAG_LARGE) begin
         n = pg_cnt[pg];
         for (i = 0; i < n && pg + i < NPG; i++) page_release(pg + i);
         pool_free += i * PG_BYTES;
         return scpa_pkg::STATUS_OK;
      end
      c = pg_tag[pg];
      sl = cls_slots(c);
      s = (o - HDR) / cls_size(c);
      if (s >= sl) return scpa_pkg::STATUS_INVALID;
      if (!pg_map[pg][s]) return scpa_pkg::STATUS_INVALID;
      pg_map[pg][s] = 1'b0;
      pg_cnt[pg]++;
      pool_free += cls_size(c);
      if (pg_cnt[pg] == sl) begin
         cur = cls_head[c];
         steps = 0;
         if (cur == pg) begin
            cls_head[c] = pg_link[pg];
         end else begin
            while (cur < NPG && steps <= NPG) begin
               steps++;
               if (pg_link[cur] == pg) begin
                  pg_link[cur] = pg_link[pg];
                  break;
               end
               cur = pg_link[cur];
            end
         end
         page_release(pg);
         pool_free = pool_free + PG_BYTES - sl * cls_size(c);
      end
      return scpa_pkg::STATUS_OK;
   endfunction

   function automatic grant_type pool_step(logic cmd, int req, int off);
      grant_type r;
      int gr;
      int c;
      gr = 0;
      if (cmd == CMD_ALLOC) begin
         if (req == 0) begin
            r.status = scpa_pkg::STATUS_INVALID;
         end else begin
            for (c = 0; c < NCLS; c++) if (req <= cls_size(c)) break;
            if (c < NCLS) alloc_slot(c, r.status, gr);
            else alloc_run(req, r.status, gr);
         end
         if (r.status != scpa_pkg::STATUS_OK) gr = 0;
      end else begin
         r.status = release_block(off);
      end
      r.granted = gr[17:0];
      r.free_bytes = pool_free[18:0];
      return r;
   endfunction

   // send one beat, predict on acceptance
   task automatic send_beat(logic cmd, int req, int off);
      grant_type r;
      while (!calm && $urandom_range(99) < 34) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {3'b0, off[17:0], req[18:0]};
      do @(posedge clock); while (!req_tready);
      r = pool_step(cmd, req, off);
      grant_q.push_back(r);
      last_grant = r.granted;
      n_sent++;
      if (cmd == CMD_ALLOC && r.status == scpa_pkg::STATUS_OK) begin
         live_off.push_back(r.granted);
         live_span.push_back(req > 2048 ? PG_BYTES - HDR : cls_size($clog2((req + 15) / 16)));
      end
   endtask

   task automatic end_of_traffic();
      @(posedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      end_of_traffic();
      while (grant_q.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
   end

   always @(posedge clock) begin
      grant_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_rsp++;
         if (grant_q.size() == 0) begin
            $display("%0t unexpected beat actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            e = grant_q.pop_front();
            if (rsp_tdata[1:0] !== e.status) begin
               $display("%0t status expected %0d actual %0d", $time, e.status, rsp_tdata[1:0]);
               errors++;
            end
            if (rsp_tdata[19:2] !== e.granted) begin
               $display("%0t granted_offset expected %0d actual %0d", $time, e.granted,
                        rsp_tdata[19:2]);
               errors++;
            end
            if (rsp_tdata[38:20] !== e.free_bytes) begin
               $display("%0t free_bytes expected %0d actual %0d", $time, e.free_bytes,
                        rsp_tdata[38:20]);
               errors++;
            end
         end
      end
   end

   // watchdog on beats in either direction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG) begin
         $display("%0t watchdog expired, %0d beats outstanding", $time, grant_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic test_small_classes();
      int g1;
      int g5;
      send_beat(CMD_ALLOC, 0, 0);
      send_beat(CMD_ALLOC, 1, 0);
      g1 = last_grant;
      send_beat(CMD_ALLOC, 16, 0);
      send_beat(CMD_ALLOC, 17, 0);
      send_beat(CMD_ALLOC, 2048, 0);
      g5 = last_grant;
      send_beat(CMD_ALLOC, 2048, 0);
      send_beat(scpa_pkg::CMD_FREE, 0, g5 + 2048);
      send_beat(scpa_pkg::CMD_FREE, 0, g1 + 15);
      send_beat(scpa_pkg::CMD_FREE, 0, g1);
      send_beat(scpa_pkg::CMD_FREE, 0, g5);
   endtask

   task automatic test_large_runs();
      int gl;
      send_beat(CMD_ALLOC, 2049, 0);
      send_beat(CMD_ALLOC, 4048, 0);
      send_beat(CMD_ALLOC, 4049, 0);
      gl = last_grant;
      send_beat(CMD_ALLOC, 262144, 0);
      send_beat(scpa_pkg::CMD_FREE, 0, gl + PG_BYTES);
      send_beat(scpa_pkg::CMD_FREE, 0, gl - HDR + 10);
      send_beat(scpa_pkg::CMD_FREE, 0, gl + 100);
   endtask

   task automatic test_bad_frees();
      send_beat(scpa_pkg::CMD_FREE, 0, 262143);
      send_beat(scpa_pkg::CMD_FREE, 0, 0);
      send_beat(scpa_pkg::CMD_FREE, 0, 5 * PG_BYTES + 200);
   endtask

   task automatic test_random_mix(int count);
      int req;
      int off;
      int k;
      int c;
      for (int n = 0; n < count; n++) begin
         calm = (n >= 200 && n < 300);
         if (n == count / 2) wait_drained();
         if ($urandom_range(99) < 55 || live_off.size() == 0) begin
            k = $urandom_range(99);
            if (k < 80) begin
               c = $urandom_range(NCLS - 1);
               req = $urandom_range(cls_size(c), c == 0 ? 1 : cls_size(c) / 2 + 1);
            end else if (k < 96) begin
               req = $urandom_range(12000, 2049);
            end else if (k < 98) begin
               req = $urandom_range(262144, 0);
            end else begin
               req = 0;
            end
            send_beat(CMD_ALLOC, req, $urandom_range(262143));
         end else begin
            if ($urandom_range(99) < 80) begin
               k = $urandom_range(live_off.size() - 1);
               off = live_off[k] + $urandom_range(live_span[k] - 1);
               live_off.delete(k);
               live_span.delete(k);
            end else begin
               off = $urandom_range(262143);
            end
            send_beat(scpa_pkg::CMD_FREE, $urandom_range(524287), off);
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      pool_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_small_classes();
      test_large_runs();
      test_bad_frees();
      test_random_mix(680);
      end_of_traffic();
      while (grant_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("covered %0d commands and %0d responses: all size classes, page runs,", n_sent,
               n_rsp);
      $display("rejected frees, pool exhaustion, random stalls and a full drain");
      if (errors == 0 && grant_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
